[rtl/core/lcd_nibble_expander_writer_macros.svh]
// assertion helpers shared by the writer rtl
`ifndef LCD_NIBBLE_EXPANDER_WRITER_MACROS_SVH
`define LCD_NIBBLE_EXPANDER_WRITER_MACROS_SVH

// same-cycle implication, skipped while in reset
`define LNX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lnx same-cycle check failed");

// next-cycle implication, skipped while in reset
`define LNX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lnx next-cycle check failed");

`endif

[rtl/core/lnx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lnx_pkg;

  localparam logic [7:0] INSTR_BL_ON  = 8'h28;
  localparam logic [7:0] INSTR_BL_OFF = 8'h2B;
  localparam logic [7:0] BL_PAUSE_US  = 8'd150;
  localparam logic [7:0] CMD_BYTE     = 8'h01;

  localparam logic [7:0] CFG_RS_MASK    = 8'd0;
  localparam logic [7:0] CFG_EN_MASK    = 8'd1;
  localparam logic [7:0] CFG_BL_MASK    = 8'd2;
  localparam logic [7:0] CFG_DATA_MASKS = 8'd3;
  localparam logic [7:0] CFG_BL_INV     = 8'd4;
  localparam logic [7:0] CFG_BL_PRESENT = 8'd5;
  localparam logic [7:0] CFG_BUS_DELAY  = 8'd6;
  localparam logic [7:0] CFG_TWO_BYTE   = 8'd7;

  typedef struct packed {
    logic [7:0]  rs_line_mask;
    logic [7:0]  enable_line_mask;
    logic [7:0]  backlight_line_mask;
    logic [31:0] data_line_masks;
    logic        backlight_inverted;
    logic        backlight_present;
    logic        bus_delay_enable;
    logic        two_byte_mode;
  } cfg_t;

  // place of the current write within one nibble
  typedef enum logic [2:0] {
    STB_SET  = 3'b001,
    STB_HIGH = 3'b010,
    STB_LOW  = 3'b100
  } strobe_t;

  function automatic logic [7:0] map_nibble(input logic [3:0] nib, input logic [31:0] masks);
    logic [7:0] v;
    v = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (nib[i]) begin
        v = v | masks[8*i +: 8];
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/lnx_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lnx_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       is_data;
  logic [7:0] byte_value;
  logic       backlight_state;

  modport source (output valid, req_type, is_data, byte_value, backlight_state, input ready);
  modport sink (input valid, req_type, is_data, byte_value, backlight_state, output ready);
endinterface

`default_nettype wire

[rtl/core/lnx_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lnx_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       end_of_write;
  logic [7:0] wait_us;
  logic       last;

  modport source (output valid, bus_byte, end_of_write, wait_us, last, input ready);
  modport sink (input valid, bus_byte, end_of_write, wait_us, last, output ready);
endinterface

`default_nettype wire

[rtl/core/lnx_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lnx_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/lnx_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module lnx_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst,
  lnx_cfg_if.sink      cfg,
  output lnx_pkg::cfg_t regs
);

  assign cfg.ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rs_line_mask        <= 8'h10;
      regs.enable_line_mask    <= 8'h40;
      regs.backlight_line_mask <= 8'h80;
      regs.data_line_masks     <= 32'h0804_0201;
      regs.backlight_inverted  <= 1'b0;
      regs.backlight_present   <= 1'b1;
      regs.bus_delay_enable    <= 1'b1;
      regs.two_byte_mode       <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        lnx_pkg::CFG_RS_MASK:    regs.rs_line_mask        <= cfg.data[7:0];
        lnx_pkg::CFG_EN_MASK:    regs.enable_line_mask    <= cfg.data[7:0];
        lnx_pkg::CFG_BL_MASK:    regs.backlight_line_mask <= cfg.data[7:0];
        lnx_pkg::CFG_DATA_MASKS: regs.data_line_masks     <= cfg.data;
        lnx_pkg::CFG_BL_INV:     regs.backlight_inverted  <= cfg.data[0];
        lnx_pkg::CFG_BL_PRESENT: regs.backlight_present   <= cfg.data[0];
        lnx_pkg::CFG_BUS_DELAY:  regs.bus_delay_enable    <= cfg.data[0];
        lnx_pkg::CFG_TWO_BYTE:   regs.two_byte_mode       <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/lcd_nibble_expander_writer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Character display writer over an 8-bit port expander, 4-bit bus mode.
// req channel: one request per handshake, either a byte to send (instruction
//   or data) or a backlight state. res channel: one bus byte per handshake,
//   with end_of_write on the last byte of each expander write, wait_us to
//   pause afterwards and last on the final byte of the request.
// cfg channel: register writes, ready whenever out of reset. The user must see
//   that they are taken only while idle; the block does not enforce it.
// A send gives 6 port writes (12 bytes in two-byte mode); a backlight request
//   gives 1 write, or 7 if the state changed (up to 14 bytes). A taken request
//   is registered, then its first byte enters the output register.
// Throughput: one result byte per cycle unless the receiver stalls, set by the write
//   sequencer that walks command byte, nibble and strobe phase. The next request
//   is taken in the cycle the current one's final byte enters the output register.
// Reset: configuration returns to its defaults, backlight line active,
//   previous backlight state off, no request in flight, nothing taken.
// Receiver stall: the output register holds its byte and the sequencer halts;
//   one further request can be taken only when the current one is finished.
`include "lcd_nibble_expander_writer_macros.svh"

module lcd_nibble_expander_writer (
  input wire logic clk,
  input wire logic rst,
  lnx_req_if.sink   req,
  lnx_res_if.source res,
  lnx_cfg_if.sink   cfg
);

  lnx_pkg::cfg_t   regs;
  lnx_pkg::strobe_t strb;

  logic       busy;
  logic       in_pre;
  logic       has_send;
  logic       long_wait;
  logic [7:0] ctl;
  logic [7:0] blv;
  logic [7:0] ch;
  logic       nib;
  logic       cmd_done;
  logic       bl_active;
  logic       prev_bl;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_eow;
  logic [7:0] out_wait;
  logic       out_last;

  logic       accept;
  logic       emit;
  logic       cmd_phase;
  logic       final_write;
  logic       final_res;
  logic       new_active;
  logic [7:0] data_val;
  logic [7:0] wr_val;
  logic [7:0] wr_wait;
  logic [7:0] delay;

  lnx_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  always_comb begin
    new_active = regs.backlight_present &
                 (regs.backlight_inverted ? req.backlight_state : ~req.backlight_state);
    delay      = {7'd0, regs.bus_delay_enable};
    cmd_phase  = regs.two_byte_mode & ~cmd_done;
    data_val   = ctl | lnx_pkg::map_nibble(nib ? ch[3:0] : ch[7:4], regs.data_line_masks);
    if (in_pre) begin
      final_write = ~has_send;
      wr_val      = blv;
      wr_wait     = 8'd0;
    end else begin
      final_write = nib && (strb == lnx_pkg::STB_LOW);
      case (strb)
        lnx_pkg::STB_SET: begin
          wr_val  = data_val;
          wr_wait = delay;
        end
        lnx_pkg::STB_HIGH: begin
          wr_val  = data_val | regs.enable_line_mask;
          wr_wait = delay;
        end
        default: begin
          wr_val  = data_val;
          wr_wait = (final_write && long_wait) ? lnx_pkg::BL_PAUSE_US : 8'd0;
        end
      endcase
    end
    final_res = final_write & ~cmd_phase;
    emit      = busy & (~out_valid | res.ready);
    req.ready = ~rst & (~busy | (emit & final_res));
    accept    = req.valid & req.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bl_active <= 1'b1;
      prev_bl   <= 1'b0;
      in_pre    <= 1'b0;
      nib       <= 1'b0;
      strb      <= lnx_pkg::STB_SET;
      cmd_done  <= 1'b0;
    end else if (accept) begin
      busy     <= 1'b1;
      in_pre   <= req.req_type;
      nib      <= 1'b0;
      strb     <= lnx_pkg::STB_SET;
      cmd_done <= 1'b0;
      if (req.req_type) begin
        bl_active <= new_active;
        prev_bl   <= req.backlight_state;
      end
    end else if (emit) begin
      if (cmd_phase) begin
        cmd_done <= 1'b1;
      end else begin
        cmd_done <= 1'b0;
        if (final_write) begin
          busy <= 1'b0;
        end else if (in_pre) begin
          in_pre <= 1'b0;
        end else begin
          case (strb)
            lnx_pkg::STB_SET:  strb <= lnx_pkg::STB_HIGH;
            lnx_pkg::STB_HIGH: strb <= lnx_pkg::STB_LOW;
            default: begin
              strb <= lnx_pkg::STB_SET;
              nib  <= 1'b1;
            end
          endcase
        end
      end
    end
  end

  // request payload, captured with the backlight state it runs under
  always_ff @(posedge clk) begin
    if (accept) begin
      long_wait <= req.req_type;
      has_send  <= ~req.req_type | (req.backlight_state != prev_bl);
      blv       <= new_active ? regs.backlight_line_mask : 8'h00;
      if (req.req_type) begin
        ctl <= new_active ? regs.backlight_line_mask : 8'h00;
        ch  <= req.backlight_state ? lnx_pkg::INSTR_BL_ON : lnx_pkg::INSTR_BL_OFF;
      end else begin
        ctl <= (req.is_data ? regs.rs_line_mask : 8'h00) |
               (bl_active ? regs.backlight_line_mask : 8'h00);
        ch  <= req.byte_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= cmd_phase ? lnx_pkg::CMD_BYTE : wr_val;
      out_eow  <= ~cmd_phase;
      out_wait <= cmd_phase ? 8'd0 : wr_wait;
      out_last <= final_res;
    end
  end

  assign res.valid        = out_valid;
  assign res.bus_byte     = out_byte;
  assign res.end_of_write = out_eow;
  assign res.wait_us      = out_wait;
  assign res.last         = out_last;

  `LNX_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `LNX_ASSERT_NOW(a_last_ends_write, clk, rst, out_valid && out_last, out_eow)
  `LNX_ASSERT_NOW(a_long_pause_last, clk, rst, out_valid && out_wait == lnx_pkg::BL_PAUSE_US,
                  out_last)
  `LNX_ASSERT_NEXT(a_stall_holds_seq, clk, rst, busy && !emit && !accept,
                   busy && $stable(strb) && $stable(nib) && $stable(cmd_done))

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic REQ_SEND      = 1'b0;
  localparam logic REQ_BACKLIGHT = 1'b1;
  localparam logic [7:0] CFG_BAD_INDEX = 8'd8;
  localparam logic [7:0] CFG_TOP_INDEX = 8'hFF;

  typedef struct packed {
    logic       req_type;
    logic       is_data;
    logic [7:0] byte_value;
    logic       backlight_state;
  } lcd_req_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       end_of_write;
    logic [7:0] wait_us;
    logic       last;
  } bus_beat_t;

  // expected bus bytes for every accepted request, checked in order
  class lcd_bus_tracker;
    lnx_pkg::cfg_t regs;
    logic       bl_line_on;
    logic       last_bl_req;
    bus_beat_t  due[$];
    int         mismatches;
    int         beats_seen;

    function new();
      regs.rs_line_mask        = 8'h10;
      regs.enable_line_mask    = 8'h40;
      regs.backlight_line_mask = 8'h80;
      regs.data_line_masks     = 32'h0804_0201;
      regs.backlight_inverted  = 1'b0;
      regs.backlight_present   = 1'b1;
      regs.bus_delay_enable    = 1'b1;
      regs.two_byte_mode       = 1'b0;
      bl_line_on  = 1'b1;
      last_bl_req = 1'b0;
      mismatches  = 0;
      beats_seen  = 0;
    endfunction

    function void note_config(logic [7:0] idx, logic [31:0] val);
      case (idx)
        lnx_pkg::CFG_RS_MASK:    regs.rs_line_mask = val[7:0];
        lnx_pkg::CFG_EN_MASK:    regs.enable_line_mask = val[7:0];
        lnx_pkg::CFG_BL_MASK:    regs.backlight_line_mask = val[7:0];
        lnx_pkg::CFG_DATA_MASKS: regs.data_line_masks = val;
        lnx_pkg::CFG_BL_INV:     regs.backlight_inverted = val[0];
        lnx_pkg::CFG_BL_PRESENT: regs.backlight_present = val[0];
        lnx_pkg::CFG_BUS_DELAY:  regs.bus_delay_enable = val[0];
        lnx_pkg::CFG_TWO_BYTE:   regs.two_byte_mode = val[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] spread_nibble(logic [3:0] nib);
      return ({8{nib[0]}} & regs.data_line_masks[7:0])
           | ({8{nib[1]}} & regs.data_line_masks[15:8])
           | ({8{nib[2]}} & regs.data_line_masks[23:16])
           | ({8{nib[3]}} & regs.data_line_masks[31:24]);
    endfunction

    function void port_write(logic [7:0] val, logic [7:0] pause);
      bus_beat_t b;
      if (regs.two_byte_mode) begin
        b.bus_byte = lnx_pkg::CMD_BYTE;
        b.end_of_write = 1'b0;
        b.wait_us = 8'd0;
        b.last = 1'b0;
        due.push_back(b);
      end
      b.bus_byte = val;
      b.end_of_write = 1'b1;
      b.wait_us = pause;
      b.last = 1'b0;
      due.push_back(b);
    endfunction

    function void char_writes(logic rs, logic [7:0] ch);
      logic [7:0] ctl;
      logic [7:0] v;
      logic [7:0] d;
      ctl = rs ? regs.rs_line_mask : 8'h00;
      if (bl_line_on) begin
        ctl = ctl | regs.backlight_line_mask;
      end
      d = regs.bus_delay_enable ? 8'd1 : 8'd0;
      for (int h = 0; h < 2; h++) begin
        v = ctl | spread_nibble(h == 0 ? ch[7:4] : ch[3:0]);
        port_write(v, d);
        port_write(v | regs.enable_line_mask, d);
        port_write(v, 8'd0);
      end
    endfunction

    function void note_request(lcd_req_t r);
      bus_beat_t tail;
      if (r.req_type == REQ_SEND) begin
        char_writes(r.is_data, r.byte_value);
      end else begin
        bl_line_on = regs.backlight_present &&
                     (regs.backlight_inverted ? r.backlight_state : !r.backlight_state);
        port_write(bl_line_on ? regs.backlight_line_mask : 8'h00, 8'd0);
        if (r.backlight_state != last_bl_req) begin
          char_writes(1'b0, r.backlight_state ? lnx_pkg::INSTR_BL_ON : lnx_pkg::INSTR_BL_OFF);
          // display needs a long pause after the mode instruction
          tail = due.pop_back();
          tail.wait_us = lnx_pkg::BL_PAUSE_US;
          due.push_back(tail);
        end
        last_bl_req = r.backlight_state;
      end
      tail = due.pop_back();
      tail.last = 1'b1;
      due.push_back(tail);
    endfunction

    function void check_beat(bus_beat_t got);
      bus_beat_t want;
      beats_seen++;
      if (due.size() == 0) begin
        $display("%0t: unexpected bus byte, expected none, actual %h", $time, got.bus_byte);
        mismatches++;
        return;
      end
      want = due.pop_front();
      if (got.bus_byte !== want.bus_byte) begin
        $display("%0t: bus_byte expected %h actual %h", $time, want.bus_byte, got.bus_byte);
        mismatches++;
      end
      if (got.end_of_write !== want.end_of_write) begin
        $display("%0t: end_of_write expected %b actual %b", $time,
                 want.end_of_write, got.end_of_write);
        mismatches++;
      end
      if (got.wait_us !== want.wait_us) begin
        $display("%0t: wait_us expected %0d actual %0d", $time, want.wait_us, got.wait_us);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic calm;
  int   n_sends;
  int   n_backlight;
  int   n_settings;

  lcd_bus_tracker tracker = new;
  bus_beat_t      seen_beat;

  lnx_req_if req_ch();
  lnx_res_if res_ch();
  lnx_cfg_if cfg_ch();

  lcd_nibble_expander_writer u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // receiver side: check on handshake, stall at random
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_beat.bus_byte = res_ch.bus_byte;
      seen_beat.end_of_write = res_ch.end_of_write;
      seen_beat.wait_us = res_ch.wait_us;
      seen_beat.last = res_ch.last;
      tracker.check_beat(seen_beat);
    end
    res_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
  end

  task automatic push_request(input lcd_req_t r);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.is_data <= r.is_data;
    req_ch.byte_value <= r.byte_value;
    req_ch.backlight_state <= r.backlight_state;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(r);
    if (r.req_type == REQ_SEND) begin
      n_sends++;
    end else begin
      n_backlight++;
    end
  endtask

  task automatic send_char(input logic rs, input logic [7:0] ch);
    lcd_req_t r;
    r.req_type = REQ_SEND;
    r.is_data = rs;
    r.byte_value = ch;
    r.backlight_state = 1'($urandom_range(0, 1));
    push_request(r);
  endtask

  task automatic set_backlight(input logic st);
    lcd_req_t r;
    r.req_type = REQ_BACKLIGHT;
    r.is_data = 1'($urandom_range(0, 1));
    r.byte_value = 8'($urandom_range(0, 255));
    r.backlight_state = st;
    push_request(r);
  endtask

  // wait for the block to go idle before touching registers
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.due.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.note_config(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input lnx_pkg::cfg_t c);
    write_reg(lnx_pkg::CFG_RS_MASK, {24'h0, c.rs_line_mask});
    write_reg(lnx_pkg::CFG_EN_MASK, {24'h0, c.enable_line_mask});
    write_reg(lnx_pkg::CFG_BL_MASK, {24'h0, c.backlight_line_mask});
    write_reg(lnx_pkg::CFG_DATA_MASKS, c.data_line_masks);
    write_reg(lnx_pkg::CFG_BL_INV, {31'h0, c.backlight_inverted});
    write_reg(lnx_pkg::CFG_BL_PRESENT, {31'h0, c.backlight_present});
    write_reg(lnx_pkg::CFG_BUS_DELAY, {31'h0, c.bus_delay_enable});
    write_reg(lnx_pkg::CFG_TWO_BYTE, {31'h0, c.two_byte_mode});
    n_settings++;
  endtask

  initial begin
    lnx_pkg::cfg_t c;
    lcd_req_t  r;

    rst = 1'b1;
    calm = 1'b0;
    n_sends = 0;
    n_backlight = 0;
    n_settings = 1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_SEND;
    req_ch.is_data = 1'b0;
    req_ch.byte_value = 8'h00;
    req_ch.backlight_state = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = lnx_pkg::CFG_RS_MASK;
    cfg_ch.data = 32'h0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: both request kinds, state changes and repeats
    send_char(1'b0, 8'h00);
    send_char(1'b1, 8'hFF);
    send_char(1'b0, 8'hA5);
    send_char(1'b1, 8'h5A);
    set_backlight(1'b1);
    set_backlight(1'b1);
    send_char(1'b1, 8'h3C);
    set_backlight(1'b0);
    set_backlight(1'b0);
    send_char(1'b1, 8'hC3);
    drain();

    // indexes past the register file must change nothing
    write_reg(CFG_BAD_INDEX, 32'hFFFF_FFFF);
    write_reg(CFG_TOP_INDEX, 32'h0000_0000);
    send_char(1'b1, 8'h96);
    drain();

    // everything set: overlapping lines, inverted rule, two-byte mode
    c = '1;
    load_setting(c);
    set_backlight(1'b1);
    send_char(1'b0, 8'h00);
    send_char(1'b1, 8'hFF);
    set_backlight(1'b0);
    set_backlight(1'b0);
    drain();

    // everything clear: no backlight fitted, no bus delay
    c = '0;
    load_setting(c);
    set_backlight(1'b1);
    send_char(1'b1, 8'h81);
    set_backlight(1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      c.rs_line_mask = 8'($urandom_range(0, 255));
      c.enable_line_mask = 8'($urandom_range(0, 255));
      c.backlight_line_mask = 8'($urandom_range(0, 255));
      c.data_line_masks = $urandom;
      c.backlight_inverted = 1'($urandom_range(0, 1));
      c.backlight_present = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      c.bus_delay_enable = 1'($urandom_range(0, 1));
      c.two_byte_mode = ph[0];
      load_setting(c);
      calm = (ph == 3);
      for (int k = 0; k < 40; k++) begin
        r.req_type = ($urandom_range(0, 9) < 3) ? REQ_BACKLIGHT : REQ_SEND;
        r.is_data = 1'($urandom_range(0, 1));
        r.byte_value = 8'($urandom_range(0, 255));
        r.backlight_state = 1'($urandom_range(0, 1));
        push_request(r);
      end
      drain();
      calm = 1'b0;
    end

    repeat (20) @(posedge clk);
    $display("covered %0d sends and %0d backlight requests over %0d register settings",
             n_sends, n_backlight, n_settings);
    $display("checked %0d bus bytes, %0d still outstanding",
             tracker.beats_seen, tracker.due.size());
    if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("%0t: timeout with %0d bus bytes outstanding", $time, tracker.due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
